// ===== src/imft_pkg.sv =====
// Shared types, constants and helper functions of the IPv4 mask filter table.
`default_nettype none

package imft_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int ADDR_W   = 32;
    localparam int SLOT_W   = 10;
    localparam int USED_W   = 11;
    localparam int CMD_W    = 2;
    localparam int OCTET_W  = 8;
    localparam int OCTETS   = ADDR_W / OCTET_W;

    localparam logic [OCTET_W-1:0] OCTET_MAX = 8'hFF;

    // Command queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CHECK  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_back_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
    } t_imft_in;

    typedef struct packed {
        logic              blocked;
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [USED_W-1:0] slots_used;
    } t_imft_out;

    // Classified command word handed from the front end to the back end.
    typedef struct packed {
        t_cmd              op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
    } t_imft_job;

    typedef struct packed {
        logic              used;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] pattern;
    } t_imft_entry;

    // Every nonzero octet of a pattern must match exactly; zero octets are wildcards.
    function automatic logic [ADDR_W-1:0] mask_of_pattern(input logic [ADDR_W-1:0] pat);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int k = 0; k < OCTETS; k++) begin
            m[k*OCTET_W +: OCTET_W] = (pat[k*OCTET_W +: OCTET_W] != '0) ? OCTET_MAX : '0;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/ip_mask_filter_table.sv =====
// Top level of the IPv4 mask/compare filter table.
//
// A command word (check, add or remove, with an address or dotted pattern) is
// taken at a rising edge where start is high and busy is low. The front end
// classifies it and places it in a two-word queue, so up to two further words
// are taken while the back end is still scanning.
// The back end walks the entry memory from slot 0 up to the high-water count,
// one slot per cycle through a single read port, and stops at the first hit.
// The back end takes one word at a time; a word that waits in the queue
// waits for the scans of the words ahead of it.
// Each result is shown for exactly one cycle with o_res_valid high; there is
// no back pressure on the result side.
// The ban_mode register is written through the cfg channel, which is always
// ready; the user must write it only while no word is in flight. The block
// itself does not enforce this.
// Reset empties the queue, clears the high-water count (so every slot is
// free) and sets ban_mode to 1. No clearing pass is needed.
`default_nettype none

module ip_mask_filter_table
    import imft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_imft_in  i_cmd,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_data,
    output logic           o_res_valid,
    output t_imft_out      o_result
);

    logic       r_ban_mode;
    logic       job_valid;
    logic       job_pop;
    t_imft_job  job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ban_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ban_mode <= i_cfg_data;
        end
    end

    imft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .o_busy      (busy),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    imft_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .i_ban_mode  (r_ban_mode),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== src/imft_front.sv =====
// Front end: accepts commands, derives the pattern mask and queues the word.
`default_nettype none

module imft_front
    import imft_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_imft_in  i_cmd,
    output logic           o_busy,
    output logic           o_job_valid,
    output t_imft_job      o_job,
    input  wire logic      i_job_pop
);

    t_imft_job          r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, n_wr;
    logic [QPTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               push;
    logic               pop;
    t_imft_job          job_in;

    assign o_busy      = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rd];

    assign push = i_start && !o_busy;
    assign pop  = i_job_pop && o_job_valid;

    always_comb begin
        job_in.op   = t_cmd'(i_cmd.command);
        job_in.addr = i_cmd.address;
        job_in.mask = mask_of_pattern(i_cmd.address);
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= job_in;
        end
    end

endmodule

`default_nettype wire

// ===== src/imft_back.sv =====
// Back end: scans the entry memory one slot per cycle and applies the command.
`default_nettype none

module imft_back
    import imft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_job_valid,
    input  wire t_imft_job  i_job,
    output logic            o_job_pop,
    input  wire logic       i_ban_mode,
    output logic            o_res_valid,
    output t_imft_out       o_result
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    t_imft_entry        mem [TABLE_DEPTH];
    t_imft_entry        r_rd_data;

    t_back_state        r_state, n_state;
    t_cmd               r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_mask;
    logic [CNT_W-1:0]   r_lim;
    logic [CNT_W-1:0]   r_rd_idx;
    logic [CNT_W-1:0]   r_cmp_idx;
    logic               r_cmp_vld;
    logic               r_hit;
    logic [IDX_W-1:0]   r_slot;
    logic [CNT_W-1:0]   r_used, n_used;
    logic               r_res_valid;
    t_imft_out          r_result, n_result;

    logic               rd_en;
    logic               entry_hit;
    logic               scan_hit;
    logic               scan_end;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    t_imft_entry        wr_data;

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

    // Match test of the word coming out of the memory against the current command.
    always_comb begin
        unique case (r_op)
            CMD_CHECK:  entry_hit = r_rd_data.used &&
                                    ((r_addr & r_rd_data.mask) == r_rd_data.pattern);
            CMD_ADD:    entry_hit = !r_rd_data.used;
            CMD_REMOVE: entry_hit = r_rd_data.used && (r_rd_data.mask == r_mask) &&
                                    (r_rd_data.pattern == r_addr);
            default:    entry_hit = 1'b0;
        endcase
        scan_hit = r_cmp_vld && entry_hit;
        scan_end = scan_hit || (r_cmp_vld && (r_cmp_idx == r_lim - CNT_W'(1)));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.op == CMD_NOP || r_used == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_idx    = r_slot;
        wr_data   = '{used: 1'b1, mask: r_mask, pattern: r_addr};
        n_used    = r_used;
        n_result  = '{blocked: 1'b0, status: ST_DONE, slot: '0,
                      slots_used: USED_W'(r_used)};
        unique case (r_state)
            S_IDLE: o_job_pop = i_job_valid;
            S_SCAN: rd_en = (r_rd_idx < r_lim);
            S_DONE: begin
                unique case (r_op)
                    CMD_CHECK: begin
                        n_result.blocked = r_hit ? i_ban_mode : !i_ban_mode;
                        n_result.slot    = r_hit ? SLOT_W'(r_slot) : '0;
                    end
                    CMD_ADD: begin
                        if (r_hit) begin
                            wr_en         = 1'b1;
                            n_result.slot = SLOT_W'(r_slot);
                        end else if (r_lim == DEPTH_CNT) begin
                            n_result.status = ST_FULL;
                        end else begin
                            // No free slot below the high-water mark: grow by one.
                            wr_en         = 1'b1;
                            wr_idx        = r_lim[IDX_W-1:0];
                            n_used        = r_lim + CNT_W'(1);
                            n_result.slot = SLOT_W'(r_lim[IDX_W-1:0]);
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_hit) begin
                            wr_en         = 1'b1;
                            wr_data.used  = 1'b0;
                            n_result.slot = SLOT_W'(r_slot);
                        end else begin
                            n_result.status = ST_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
                n_result.slots_used = USED_W'(n_used);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_res_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_res_valid <= (r_state == S_DONE);
            r_cmp_vld   <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            r_op     <= i_job.op;
            r_addr   <= i_job.addr;
            r_mask   <= i_job.mask;
            r_lim    <= r_used;
            r_rd_idx <= '0;
            r_hit    <= 1'b0;
            r_slot   <= '0;
        end else if (r_state == S_SCAN) begin
            if (rd_en) begin
                r_rd_idx  <= r_rd_idx + CNT_W'(1);
                r_cmp_idx <= r_rd_idx;
            end
            if (scan_hit) begin
                r_hit  <= 1'b1;
                r_slot <= r_cmp_idx[IDX_W-1:0];
            end
        end
        if (r_state == S_DONE) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_rd_idx[IDX_W-1:0]];
        end
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/imft_checker.sv =====
// Port-level checks of the filter table and the bind that attaches them.
`default_nettype none

module imft_checker
    import imft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      busy,
    input wire logic      o_res_valid,
    input wire t_imft_out o_result
);

    localparam logic [USED_W-1:0] FULL_USED = USED_W'(TABLE_DEPTH);

    // Reset empties the queue, so busy is low after it, and leaves no result pending.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_res_valid)
        else $error("busy or result strobe right after reset");

    // Result strobes never come back to back.
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe high for two cycles");

    // A failed add or remove names no slot and blocks nothing.
    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.status != ST_DONE |->
            o_result.slot == '0 && !o_result.blocked)
        else $error("slot or blocked set on a failed command");

    // Full is reported only once every slot is in the table.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.status == ST_FULL |-> o_result.slots_used == FULL_USED)
        else $error("table full reported below the table depth");

endmodule

bind ip_mask_filter_table imft_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_imft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_result    (o_result)
);

`default_nettype wire

// ===== verif/ip_mask_filter_table_test.sv =====
// Self-checking testbench for the IPv4 mask filter table: directed cases, random traffic, full table.
module ip_mask_filter_table_test;
    import imft_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int DEPTH          = TABLE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = DEPTH + 16;
    localparam int REPORT_LIMIT   = 10;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_imft_in  i_cmd;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg_data;
    logic      o_res_valid;
    t_imft_out o_result;

    // Shadow copy of the filter table and the ban_mode register.
    logic [ADDR_W-1:0] rule_mask    [DEPTH];
    logic [ADDR_W-1:0] rule_pattern [DEPTH];
    bit                rule_free    [DEPTH];
    int                rule_high_water;
    int                rule_live;
    bit                ban_listed;

    t_imft_out pending_verdicts [$];
    t_imft_out oldest_verdict;

    bit steady_flow;
    int error_count;
    int idle_cycles;
    int words_sent;
    int check_count;
    int hit_count;
    int add_count;
    int remove_count;
    int nop_count;
    int full_count;
    int missing_count;

    ip_mask_filter_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // A nonzero octet must match exactly; a zero octet matches anything.
    function automatic logic [ADDR_W-1:0] exact_octets(input logic [ADDR_W-1:0] pat);
        exact_octets = '0;
        for (int k = 0; k < OCTETS; k++) begin
            if (pat[k*OCTET_W +: OCTET_W] != 8'h00) begin
                exact_octets[k*OCTET_W +: OCTET_W] = OCTET_MAX;
            end
        end
    endfunction

    function automatic t_imft_out predict_verdict(input t_cmd op, input logic [ADDR_W-1:0] addr);
        t_imft_out         verdict;
        logic [ADDR_W-1:0] care;
        int                span;
        int                slot_idx;
        bit                found;
        verdict = '0;
        verdict.status = ST_DONE;
        span = (rule_high_water < DEPTH) ? rule_high_water : DEPTH;
        care = exact_octets(addr);
        found = 1'b0;
        slot_idx = 0;
        case (op)
            CMD_CHECK: begin
                for (int i = 0; i < span; i++) begin
                    if (!rule_free[i] && (addr & rule_mask[i]) == rule_pattern[i]) begin
                        found = 1'b1;
                        slot_idx = i;
                        break;
                    end
                end
                verdict.blocked = found ? ban_listed : !ban_listed;
                check_count++;
                if (found) hit_count++;
            end
            CMD_ADD: begin
                add_count++;
                slot_idx = span;
                for (int i = 0; i < span; i++) begin
                    if (rule_free[i]) begin
                        slot_idx = i;
                        break;
                    end
                end
                if (slot_idx == DEPTH) begin
                    verdict.status = ST_FULL;
                    slot_idx = 0;
                    full_count++;
                end else begin
                    if (slot_idx == span) rule_high_water = span + 1;
                    rule_mask[slot_idx] = care;
                    rule_pattern[slot_idx] = addr;
                    rule_free[slot_idx] = 1'b0;
                    rule_live++;
                end
            end
            CMD_REMOVE: begin
                remove_count++;
                for (int i = 0; i < span; i++) begin
                    if (!rule_free[i] && rule_mask[i] == care && rule_pattern[i] == addr) begin
                        rule_free[i] = 1'b1;
                        rule_live--;
                        found = 1'b1;
                        slot_idx = i;
                        break;
                    end
                end
                if (!found) begin
                    verdict.status = ST_NOT_FOUND;
                    missing_count++;
                end
            end
            default: nop_count++;
        endcase
        verdict.slot = slot_idx[SLOT_W-1:0];
        verdict.slots_used = rule_high_water[USED_W-1:0];
        return verdict;
    endfunction

    // Octets lean toward zero, 0xff and a few shared values so entries overlap.
    function automatic logic [ADDR_W-1:0] random_pattern();
        logic [ADDR_W-1:0] pat;
        for (int k = 0; k < OCTETS; k++) begin
            case ($urandom_range(0, 5))
                0, 1:    pat[k*OCTET_W +: OCTET_W] = 8'h00;
                2:       pat[k*OCTET_W +: OCTET_W] = OCTET_MAX;
                3:       pat[k*OCTET_W +: OCTET_W] = 8'd10 + 8'($urandom_range(0, 2));
                default: pat[k*OCTET_W +: OCTET_W] = 8'($urandom_range(1, 255));
            endcase
        end
        return pat;
    endfunction

    function automatic logic [ADDR_W-1:0] live_pattern();
        int nth;
        nth = $urandom_range(0, rule_live - 1);
        for (int i = 0; i < rule_high_water; i++) begin
            if (!rule_free[i]) begin
                if (nth == 0) return rule_pattern[i];
                nth--;
            end
        end
        return $urandom();
    endfunction

    // Start stays high from one word to the next when there is no gap.
    task automatic send_word(input t_cmd op, input logic [ADDR_W-1:0] addr);
        int       gap;
        t_imft_in word;
        gap = steady_flow ? 0 : $urandom_range(0, 6);
        word.command = op;
        word.address = addr;
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= word;
        do @(posedge i_clk); while (busy);
        pending_verdicts.push_back(predict_verdict(op, addr));
        words_sent++;
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_ban_mode(input bit value);
        pause_until_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ban_listed = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_basics();
        send_word(CMD_CHECK,  32'h0000_0000);
        send_word(CMD_REMOVE, 32'h0A00_0001);
        send_word(CMD_NOP,    32'hFFFF_FFFF);
        send_word(CMD_ADD,    32'hFFFF_FFFF);
        send_word(CMD_ADD,    32'hC0A8_0000);
        send_word(CMD_ADD,    32'h0A00_0001);
        send_word(CMD_CHECK,  32'hFFFF_FFFF);
        send_word(CMD_CHECK,  32'hC0A8_1234);
        send_word(CMD_CHECK,  32'h0B00_0001);
        send_word(CMD_REMOVE, 32'hC0A8_0000);
        // The freed slot must no longer match.
        send_word(CMD_CHECK,  32'hC0A8_1234);
        // An all-zero pattern reuses the hole and matches everything.
        send_word(CMD_ADD,    32'h0000_0000);
        send_word(CMD_CHECK,  32'h1234_5678);
        send_word(CMD_ADD,    32'h0000_FF00);
        send_word(CMD_REMOVE, 32'hC0A8_0000);
        send_word(CMD_REMOVE, 32'h0000_0000);
        send_word(CMD_REMOVE, 32'hFFFF_FFFF);
    endtask

    task automatic test_ban_mode_switch();
        write_ban_mode(1'b0);
        send_word(CMD_CHECK, 32'h0A00_0001);
        send_word(CMD_CHECK, 32'h0102_0304);
        send_word(CMD_NOP,   32'h0000_0000);
        write_ban_mode(1'b1);
        send_word(CMD_CHECK, 32'h0A00_0001);
    endtask

    task automatic test_random_traffic(input int words, input bit ban);
        int                pick;
        logic [ADDR_W-1:0] pat;
        write_ban_mode(ban);
        steady_flow = $urandom_range(0, 1);
        repeat (words) begin
            if ($urandom_range(0, 29) == 0) steady_flow = !steady_flow;
            if ($urandom_range(0, 63) == 0) pause_until_drained();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if (rule_live > 0 && $urandom_range(0, 2) != 0) begin
                    pat = live_pattern();
                    send_word(CMD_CHECK, pat | (~exact_octets(pat) & $urandom()));
                end else begin
                    send_word(CMD_CHECK, $urandom());
                end
            end else if (pick < 70 && rule_live < 40) begin
                send_word(CMD_ADD, random_pattern());
            end else if (pick < 95) begin
                if (rule_live > 0 && $urandom_range(0, 3) != 0) send_word(CMD_REMOVE, live_pattern());
                else send_word(CMD_REMOVE, random_pattern());
            end else begin
                send_word(CMD_NOP, $urandom());
            end
        end
    endtask

    // Left for last: once the high-water count reaches the depth it never drops.
    task automatic test_full_table();
        logic [ADDR_W-1:0] pat;
        steady_flow = 1'b1;
        while (rule_live < DEPTH) send_word(CMD_ADD, random_pattern());
        steady_flow = 1'b0;
        send_word(CMD_ADD,    32'h0102_0304);
        send_word(CMD_CHECK,  $urandom());
        pat = rule_pattern[DEPTH-1];
        send_word(CMD_CHECK,  pat);
        send_word(CMD_REMOVE, pat);
        send_word(CMD_ADD,    32'hFFFF_FFFF);
        send_word(CMD_ADD,    32'h0A0A_0A0A);
        send_word(CMD_REMOVE, 32'hFE00_FE00);
        send_word(CMD_NOP,    32'h0000_0000);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (pending_verdicts.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("Result with no word outstanding: blocked %0d status %0d slot %0d used %0d",
                             o_result.blocked, o_result.status, o_result.slot,
                             o_result.slots_used);
                end
            end else begin
                oldest_verdict = pending_verdicts.pop_front();
                if (o_result.blocked !== oldest_verdict.blocked
                        || o_result.status !== oldest_verdict.status
                        || o_result.slot !== oldest_verdict.slot
                        || o_result.slots_used !== oldest_verdict.slots_used) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("Mismatch: expected blocked %0d status %0d slot %0d used %0d, got %0d %0d %0d %0d",
                                 oldest_verdict.blocked, oldest_verdict.status, oldest_verdict.slot,
                                 oldest_verdict.slots_used, o_result.blocked, o_result.status,
                                 o_result.slot, o_result.slots_used);
                    end
                end
            end
        end
    end

    // Counts cycles in which no word, result or register write moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("ip_mask_filter_table_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        idle_cycles = 0;
        foreach (rule_free[i]) rule_free[i] = 1'b1;
        rule_high_water = 0;
        rule_live = 0;
        ban_listed = 1'b1;
        steady_flow = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_ban_mode_switch();
        test_random_traffic(110, 1'b0);
        test_random_traffic(110, 1'b1);
        test_random_traffic(110, 1'b0);
        test_random_traffic(120, 1'b1);
        test_full_table();

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d words: %0d checks (%0d hits), %0d adds, %0d removes, %0d idle codes.",
                 words_sent, check_count, hit_count, add_count, remove_count, nop_count);
        $display("Saw %0d table-full and %0d not-found replies; high-water count reached %0d.",
                 full_count, missing_count, rule_high_water);
        if (error_count == 0 && pending_verdicts.size() == 0) begin
            $display("ip_mask_filter_table_test: done, clean");
        end else begin
            $display("ip_mask_filter_table_test: done, errors");
        end
        $finish;
    end

endmodule
